// File: src/tte_pkg.sv
// Shared widths, constants and codes for the Taylor tangent evaluator.
package tte_pkg;

   // Request and response payload widths
   localparam int unsigned X_W      = 16;
   localparam int unsigned TERMS_W  = 5;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned FAULT_W  = 2;

   // Fixed-point formats
   localparam int unsigned Q_FRAC   = 12;  // fraction bits of x
   localparam int unsigned OUT_FRAC = 16;  // fraction bits of result

   // Defaults for the top-level parameters
   localparam int unsigned TERMS_MAX_DEF = 16;
   localparam int unsigned FRAC_BITS_DEF = 32;

   // Datapath widths
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned HALF_W  = SUM_W / 2;
   localparam int unsigned PROD_W  = 2 * SUM_W;
   localparam int unsigned DIGIT_W = 8;

   // Term update: (mag * |x|) >> Q_FRAC, then divided by the term index
   localparam int unsigned TERM_P_W   = SUM_W + X_W;
   localparam int unsigned TERM_DIV_W = TERM_P_W - Q_FRAC;
   localparam int unsigned DIV_BYTES  = (TERM_DIV_W + DIGIT_W - 1) / DIGIT_W;
   localparam int unsigned DIV_REG_W  = DIV_BYTES * DIGIT_W;

   // Final quotient: any value at or above 2^GUARD saturates
   localparam int unsigned GUARD = RESULT_W + 1;
   localparam int unsigned CNT_W = $clog2(GUARD);

   localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
   localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

   typedef enum logic [FAULT_W-1:0] {
      FAULT_OK       = 2'd0,
      FAULT_COS_ZERO = 2'd1,
      FAULT_SAT      = 2'd2
   } fault_type;

endpackage

// File: src/tte_if.sv
// Request and response channel interfaces of the Taylor tangent evaluator.
interface tte_req_if;
   import tte_pkg::*;

   logic                valid;
   logic                ready;
   logic signed [X_W-1:0] x;
   logic [TERMS_W-1:0]  terms;
   logic                mode;

   modport source (output valid, x, terms, mode, input ready);
   modport sink   (input valid, x, terms, mode, output ready);
endinterface

interface tte_rsp_if;
   import tte_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [RESULT_W-1:0] result;
   logic [FAULT_W-1:0]       fault;

   modport source (output valid, result, fault, input ready);
   modport sink   (input valid, result, fault, output ready);
endinterface

// File: src/tte_radix_div.sv
// One radix-256 digit of long division by a small divisor.
module tte_radix_div #(
   parameter int unsigned DIV_W = 6
) (
   input  logic [DIV_W-1:0]            divisor,
   input  logic [DIV_W-1:0]            rem_in,
   input  logic [tte_pkg::DIGIT_W-1:0] digit_in,
   output logic [tte_pkg::DIGIT_W-1:0] quo,
   output logic [DIV_W-1:0]            rem_out
);
   import tte_pkg::*;

   logic [DIV_W:0] part;

   always_comb begin
      part = {1'b0, rem_in};
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         part = {part[DIV_W-1:0], digit_in[i]};
         if (part >= {1'b0, divisor}) begin
            part   = part - {1'b0, divisor};
            quo[i] = 1'b1;
         end else begin
            quo[i] = 1'b0;
         end
      end
      rem_out = part[DIV_W-1:0];
   end

endmodule

// File: src/taylor_tangent_evaluator_core.sv
// Taylor-series tan(x) and e^x * tan(x) evaluator, fixed point, one request at a time.
//
// req_if carries x (signed Q3.12), terms (0..31, clamped to TERMS_MAX) and mode
// (0: tan(x), 1: e^x * tan(x)). rsp_if returns result (signed Q16.16, saturated)
// and fault (ok, cosine sum zero, saturated). Both channels use valid/ready.
//
// With n the clamped term count, the sine and cosine sums are built over 2n terms
// and the exponential sum over the first n. Every term after the first takes two
// 32x32 partial products in the shared multiplier and nine radix-256 division digits
// by the term index. The quotient then takes the e * s product in the multiplier, one
// range check and 33 restoring division steps, one bit per cycle against the cosine sum.
// A quotient of 2^33 or more saturates without dividing, a zero cosine sum answers
// without multiplying, and n = 0 gives a zero cosine sum. One request is in flight;
// req_if.ready is high only while idle, so a new request is taken only after the
// response handshake.
//
// The response is held in registers until rsp_if.ready; no new request is taken
// while it waits. Synchronous reset returns the block to idle and drops any
// request in progress.
module taylor_tangent_evaluator_core #(
   parameter int unsigned TERMS_MAX = tte_pkg::TERMS_MAX_DEF,
   parameter int unsigned FRAC_BITS = tte_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tte_req_if.sink   req_if,
   tte_rsp_if.source rsp_if
);
   import tte_pkg::*;

   localparam int unsigned N_W   = $clog2(TERMS_MAX + 1);
   localparam int unsigned K_W   = N_W + 1;
   localparam int unsigned SHIFT = FRAC_BITS - OUT_FRAC;
   localparam logic [SUM_W-1:0] MAG_ONE = SUM_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC,
      S_MUL_LO,
      S_MUL_HI,
      S_DIV,
      S_FPREP,
      S_FMUL,
      S_FCHK,
      S_FDIV,
      S_FRES,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic                 xneg_ff, xneg_in;
   logic [X_W-1:0]       ax_ff, ax_in;
   logic                 mode_ff, mode_in;
   logic                 neg_ff, neg_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     mag_ff, mag_in;
   logic [SUM_W-1:0]     s_ff, s_in;
   logic [SUM_W-1:0]     c_ff, c_in;
   logic [SUM_W-1:0]     e_ff, e_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DIV_REG_W-1:0] div_ff, div_in;
   logic [K_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]     frem_ff, frem_in;
   logic [GUARD-1:0]     q_ff, q_in;
   logic [RESULT_W-1:0]  result_ff, result_in;
   fault_type            fault_ff, fault_in;

   // Shared multiplier and its lane placement
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [SUM_W-1:0]  pp;
   logic [1:0]        pp_lane;
   logic [PROD_W-1:0] pp_ext, pp_shifted, prod_sum;

   // Term division digit
   logic [DIGIT_W-1:0] quo_byte;
   logic [K_W-1:0]     rem_out;

   // Request decode
   logic [X_W-1:0] x_u, ax_req;
   logic [N_W-1:0] n_clamp;

   // Series accumulation
   logic             tneg, alt;
   logic [SUM_W-1:0] neg_mag, av, tv;
   logic [K_W-1:0]   k_next;

   // Final stage
   logic [SUM_W-1:0]        e_val, s_abs, c_abs, e_abs;
   logic [PROD_W-1:0]       prod_shr;
   logic [PROD_W-GUARD-1:0] quo_hi;
   logic [SUM_W:0]          r2, r2_diff;
   logic                    r2_ge;
   logic                    q_over;

   always_comb begin
      unique case (state_ff)
         S_MUL_HI: mul_a = mag_ff[SUM_W-1:HALF_W];
         S_FMUL:   mul_a = cnt_ff[1] ? e_ff[SUM_W-1:HALF_W] : e_ff[HALF_W-1:0];
         default:  mul_a = mag_ff[HALF_W-1:0];
      endcase
      if (state_ff == S_FMUL) begin
         mul_b   = cnt_ff[0] ? s_ff[SUM_W-1:HALF_W] : s_ff[HALF_W-1:0];
         pp_lane = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0]};
      end else begin
         mul_b   = HALF_W'(ax_ff);
         pp_lane = (state_ff == S_MUL_HI) ? 2'd1 : 2'd0;
      end
   end

   assign pp     = SUM_W'(mul_a) * SUM_W'(mul_b);
   assign pp_ext = PROD_W'(pp);

   always_comb begin
      unique case (pp_lane)
         2'd0:    pp_shifted = pp_ext;
         2'd1:    pp_shifted = pp_ext << HALF_W;
         default: pp_shifted = pp_ext << SUM_W;
      endcase
   end

   assign prod_sum = prod_ff + pp_shifted;

   tte_radix_div #(
      .DIV_W (K_W)
   ) u_radix_div (
      .divisor  (k_ff),
      .rem_in   (rem_ff),
      .digit_in (div_ff[DIV_REG_W-1 -: DIGIT_W]),
      .quo      (quo_byte),
      .rem_out  (rem_out)
   );

   always_comb begin
      x_u    = req_if.x;
      ax_req = x_u[X_W-1] ? (~x_u + X_W'(1)) : x_u;
      if ({1'b0, req_if.terms} > (TERMS_W + 1)'(TERMS_MAX)) begin
         n_clamp = N_W'(TERMS_MAX);
      end else begin
         n_clamp = N_W'(req_if.terms);
      end
   end

   // Term k: sign from x for odd k, alternation from bit 1 of k
   assign tneg    = xneg_ff & k_ff[0];
   assign alt     = k_ff[1];
   assign neg_mag = -mag_ff;
   assign av      = (tneg ^ alt) ? neg_mag : mag_ff;
   assign tv      = tneg ? neg_mag : mag_ff;
   assign k_next  = k_ff + K_W'(1);

   assign e_val = mode_ff ? e_ff : MAG_ONE;
   assign s_abs = s_ff[SUM_W-1] ? -s_ff : s_ff;
   assign c_abs = c_ff[SUM_W-1] ? -c_ff : c_ff;
   assign e_abs = e_val[SUM_W-1] ? -e_val : e_val;

   assign prod_shr = prod_ff >> SHIFT;
   assign quo_hi   = prod_shr[PROD_W-1:GUARD];

   assign r2      = {frem_ff, q_ff[GUARD-1]};
   assign r2_diff = r2 - {1'b0, c_ff};
   assign r2_ge   = (r2 >= {1'b0, c_ff});

   assign q_over = neg_ff ? (q_ff > GUARD'(RES_MIN)) : (q_ff > GUARD'(RES_MAX));

   always_comb begin
      state_in  = state_ff;
      xneg_in   = xneg_ff;
      ax_in     = ax_ff;
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      s_in      = s_ff;
      c_in      = c_ff;
      e_in      = e_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      frem_in   = frem_ff;
      q_in      = q_ff;
      result_in = result_ff;
      fault_in  = fault_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               xneg_in  = x_u[X_W-1];
               ax_in    = ax_req;
               mode_in  = req_if.mode;
               n_in     = n_clamp;
               mag_in   = MAG_ONE;
               s_in     = '0;
               c_in     = '0;
               e_in     = '0;
               k_in     = '0;
               state_in = (n_clamp == '0) ? S_FPREP : S_ACC;
            end
         end
         S_ACC: begin
            if (k_ff[0]) begin
               s_in = s_ff + av;
            end else begin
               c_in = c_ff + av;
            end
            if (k_ff < {1'b0, n_ff}) begin
               e_in = e_ff + tv;
            end
            k_in     = k_next;
            state_in = (k_next == {n_ff, 1'b0}) ? S_FPREP : S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = pp_shifted;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            // drop the Q3.12 fraction, then divide by k a byte at a time
            div_in   = DIV_REG_W'(prod_sum[TERM_P_W-1:Q_FRAC]);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_in = {div_ff[DIV_REG_W-DIGIT_W-1:0], quo_byte};
            rem_in = rem_out;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_BYTES - 1)) begin
               mag_in   = div_in[SUM_W-1:0];
               state_in = S_ACC;
            end
         end
         S_FPREP: begin
            if (c_ff == '0) begin
               result_in = '0;
               fault_in  = FAULT_COS_ZERO;
               state_in  = S_OUT;
            end else begin
               s_in     = s_abs;
               c_in     = c_abs;
               e_in     = e_abs;
               neg_in   = s_ff[SUM_W-1] ^ c_ff[SUM_W-1] ^ e_val[SUM_W-1];
               prod_in  = '0;
               cnt_in   = '0;
               state_in = S_FMUL;
            end
         end
         S_FMUL: begin
            prod_in = prod_sum;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(3)) begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            // quotient of 2^GUARD or more saturates without dividing
            if (quo_hi >= (PROD_W - GUARD)'(c_ff)) begin
               result_in = neg_ff ? RES_MIN : RES_MAX;
               fault_in  = FAULT_SAT;
               state_in  = S_OUT;
            end else begin
               frem_in  = quo_hi[SUM_W-1:0];
               q_in     = prod_shr[GUARD-1:0];
               cnt_in   = '0;
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            frem_in = r2_ge ? r2_diff[SUM_W-1:0] : r2[SUM_W-1:0];
            q_in    = {q_ff[GUARD-2:0], r2_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GUARD - 1)) begin
               state_in = S_FRES;
            end
         end
         S_FRES: begin
            if (q_over) begin
               result_in = neg_ff ? RES_MIN : RES_MAX;
               fault_in  = FAULT_SAT;
            end else begin
               result_in = neg_ff ? -q_ff[RESULT_W-1:0] : q_ff[RESULT_W-1:0];
               fault_in  = FAULT_OK;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      xneg_ff   <= xneg_in;
      ax_ff     <= ax_in;
      mode_ff   <= mode_in;
      neg_ff    <= neg_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      mag_ff    <= mag_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      e_ff      <= e_in;
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      frem_ff   <= frem_in;
      q_ff      <= q_in;
      result_ff <= result_in;
      fault_ff  <= fault_in;
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = (state_ff == S_OUT);
   assign rsp_if.result = result_ff;
   assign rsp_if.fault  = fault_ff;

endmodule
